>>> sv/dcr_pkg.sv
// Package for the distortion color ramp HSV converter.
// Fixed-point widths, ramp constants, the sector code type and the pipeline control struct.
// No dependencies.
`timescale 1ns / 1ps

package dcr_pkg;

	// Fraction bits of every Q1.x value and of the Q4.x ratio.
	localparam int FRAC_BITS = 16;

	localparam int ONE_W   = FRAC_BITS + 1;  // Q1.x: 0 .. 1.0 inclusive
	localparam int RATIO_W = FRAC_BITS + 4;  // Q4.x distortion ratio
	localparam int NUM_W   = FRAC_BITS + 2;  // ramp numerator 0 .. 2.0

	// Number of register stages from input to output.
	localparam int NSTG = 5;

	localparam logic [ONE_W-1:0] Q_ONE = ONE_W'(1) << FRAC_BITS;

	// Ramp saturation 0.7 and value 0.65, rounded to nearest.
	localparam logic [ONE_W-1:0] RAMP_SAT =
		ONE_W'((64'd7 * (64'd1 << FRAC_BITS) + 64'd5) / 64'd10);
	localparam logic [ONE_W-1:0] RAMP_VAL =
		ONE_W'((64'd65 * (64'd1 << FRAC_BITS) + 64'd50) / 64'd100);

	// Clamp window of the ratio: 1.0 .. 1.5.
	localparam logic [RATIO_W-1:0] RATIO_LO = RATIO_W'(64'd1 << FRAC_BITS);
	localparam logic [RATIO_W-1:0] RATIO_HI = RATIO_LO + (RATIO_LO >> 1);

	// Exact floor division by three of a numerator below 2^(FRAC_BITS+2):
	// x / 3 == (x * ceil(2^k / 3)) >> k for an even k with 2x < 2^k.
	localparam int DIV3_SHIFT = 2 * ((FRAC_BITS + 4) / 2);
	localparam int DIV3_MUL_W = DIV3_SHIFT - 1;
	localparam logic [DIV3_MUL_W-1:0] DIV3_MUL =
		DIV3_MUL_W'(((64'd1 << DIV3_SHIFT) + 64'd2) / 64'd3);

	// Hue sector, the integer part of six times the hue.
	typedef enum logic [2:0] {
		SEC_RED_YEL = 3'd0,
		SEC_YEL_GRN = 3'd1,
		SEC_GRN_CYN = 3'd2,
		SEC_CYN_BLU = 3'd3,
		SEC_BLU_MAG = 3'd4,
		SEC_MAG_RED = 3'd5
	} sector_t;

	// Per-stage load enables and valid bits, indexed by stage number.
	typedef struct packed {
		logic [NSTG:1] en;
		logic [NSTG:1] vld;
	} dcr_pipe_t;

endpackage

>>> sv/dcr_if.sv
// Stream interfaces of the distortion color ramp HSV converter: HSV input and RGB output.
// Each carries valid, ready and the payload. Depends on dcr_pkg.
`timescale 1ns / 1ps

interface dcr_hsv_if import dcr_pkg::*;;
	logic               valid;
	logic               ready;
	logic               mode;
	logic [ONE_W-1:0]   hue;
	logic [ONE_W-1:0]   sat;
	logic [ONE_W-1:0]   val;
	logic [RATIO_W-1:0] ratio;

	modport source (output valid, mode, hue, sat, val, ratio, input ready);
	modport sink   (input valid, mode, hue, sat, val, ratio, output ready);
endinterface

interface dcr_rgb_if import dcr_pkg::*;;
	logic             valid;
	logic             ready;
	logic [ONE_W-1:0] red;
	logic [ONE_W-1:0] green;
	logic [ONE_W-1:0] blue;

	modport source (output valid, red, green, blue, input ready);
	modport sink   (input valid, red, green, blue, output ready);
endinterface

>>> sv/dcr_ctrl.sv
// Pipeline control: valid bits per stage and the stall chain back to the input.
// Depends on dcr_pkg.
`timescale 1ns / 1ps

module dcr_ctrl import dcr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      out_ready,
	output logic      in_ready,
	output dcr_pipe_t pipe
);

	logic [NSTG:1] vld_q;
	logic [NSTG:1] en_c;
	logic [NSTG:1] vld_nxt;

	// A stage loads when it is empty or when the next stage loads too.
	always_comb begin
		en_c[NSTG] = !vld_q[NSTG] || out_ready;
		for (int k = NSTG - 1; k >= 1; k--) begin
			en_c[k] = !vld_q[k] || en_c[k + 1];
		end
	end

	assign vld_nxt = {vld_q[NSTG-1:1], in_valid};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 1; k <= NSTG; k++) begin
				if (en_c[k]) begin
					vld_q[k] <= vld_nxt[k];
				end
			end
		end
	end

	assign in_ready = en_c[1];
	assign pipe.en  = en_c;
	assign pipe.vld = vld_q;

endmodule

>>> sv/dcr_hue.sv
// Hue front end, stages one and two: input saturation, ratio clamp and the ramp hue.
// Depends on dcr_pkg.
`timescale 1ns / 1ps

module dcr_hue import dcr_pkg::*; (
	input  logic               clk,
	input  dcr_pipe_t          pipe,
	input  logic               mode,
	input  logic [ONE_W-1:0]   hue,
	input  logic [ONE_W-1:0]   sat,
	input  logic [ONE_W-1:0]   val,
	input  logic [RATIO_W-1:0] ratio,
	output logic [ONE_W-1:0]   h_s2,
	output logic [ONE_W-1:0]   s_s2,
	output logic [ONE_W-1:0]   v_s2
);

	logic [ONE_W-1:0]   h_c, s_c, v_c;
	logic [RATIO_W-1:0] d_c;
	logic [RATIO_W-1:0] dm_full;
	logic [NUM_W-1:0]   num_c;

	logic               mode_s1;
	logic [NUM_W-1:0]   num_s1;
	logic [ONE_W-1:0]   h_s1, s_s1, v_s1;

	logic [NUM_W+DIV3_MUL_W-1:0] prod_c;
	logic [ONE_W-1:0]            ramp_h_c;

	// Stage 1: fractions above one saturate, the ratio is clamped to 1.0 .. 1.5
	// and turned into the numerator 2 - 4(d - 1) of the ramp hue.
	always_comb begin
		h_c = (hue > Q_ONE) ? Q_ONE : hue;
		s_c = (sat > Q_ONE) ? Q_ONE : sat;
		v_c = (val > Q_ONE) ? Q_ONE : val;
		if (ratio < RATIO_LO) begin
			d_c = RATIO_LO;
		end else if (ratio > RATIO_HI) begin
			d_c = RATIO_HI;
		end else begin
			d_c = ratio;
		end
		dm_full = d_c - RATIO_LO;
		num_c   = (NUM_W'(2) << FRAC_BITS) - (NUM_W'(dm_full[FRAC_BITS-1:0]) << 2);
	end

	always_ff @(posedge clk) begin
		if (pipe.en[1]) begin
			mode_s1 <= mode;
			num_s1  <= num_c;
			h_s1    <= h_c;
			s_s1    <= s_c;
			v_s1    <= v_c;
		end
	end

	// Stage 2: divide by three through the reciprocal and pick the mode.
	assign prod_c   = {{DIV3_MUL_W{1'b0}}, num_s1} * {{NUM_W{1'b0}}, DIV3_MUL};
	assign ramp_h_c = prod_c[DIV3_SHIFT +: ONE_W];

	always_ff @(posedge clk) begin
		if (pipe.en[2]) begin
			h_s2 <= mode_s1 ? ramp_h_c : h_s1;
			s_s2 <= mode_s1 ? RAMP_SAT : s_s1;
			v_s2 <= mode_s1 ? RAMP_VAL : v_s1;
		end
	end

endmodule

>>> sv/dcr_rgb.sv
// HSV to RGB back end, stages three to five: sector split, products and channel routing.
// Depends on dcr_pkg.
`timescale 1ns / 1ps

module dcr_rgb import dcr_pkg::*; (
	input  logic             clk,
	input  dcr_pipe_t        pipe,
	input  logic [ONE_W-1:0] h_s2,
	input  logic [ONE_W-1:0] s_s2,
	input  logic [ONE_W-1:0] v_s2,
	output logic [ONE_W-1:0] red_s5,
	output logic [ONE_W-1:0] green_s5,
	output logic [ONE_W-1:0] blue_s5
);

	logic [FRAC_BITS-1:0] hw_c;
	logic [FRAC_BITS+2:0] h6_c;

	sector_t              sec_s3;
	logic [FRAC_BITS-1:0] f_s3;
	logic [ONE_W-1:0]     s_s3, v_s3;

	logic [ONE_W-1:0]             omf_c, oms_c;
	logic [ONE_W+FRAC_BITS-1:0]   sf_prod_c;
	logic [2*ONE_W-1:0]           sg_prod_c, p_prod_c;

	sector_t          sec_s4;
	logic [ONE_W-1:0] v_s4, p_s4, a_s4, b_s4;

	logic [2*ONE_W-1:0] q_prod_c, t_prod_c;
	logic [ONE_W-1:0]   q_c, t_c;

	// Stage 3: a hue of one wraps to zero (the input never exceeds one here),
	// then six times the hue splits into sector and fraction.
	assign hw_c = h_s2[FRAC_BITS] ? '0 : h_s2[FRAC_BITS-1:0];
	assign h6_c = ({3'b000, hw_c} << 2) + ({3'b000, hw_c} << 1);

	always_ff @(posedge clk) begin
		if (pipe.en[3]) begin
			sec_s3 <= sector_t'(h6_c[FRAC_BITS+2:FRAC_BITS]);
			f_s3   <= h6_c[FRAC_BITS-1:0];
			s_s3   <= s_s2;
			v_s3   <= v_s2;
		end
	end

	// Stage 4: s*f, s*(1-f) and p = v*(1-s). Zero saturation makes p, q and t
	// all equal to v, which gives grey without a separate path.
	assign omf_c     = Q_ONE - {1'b0, f_s3};
	assign oms_c     = Q_ONE - s_s3;
	assign sf_prod_c = {{FRAC_BITS{1'b0}}, s_s3} * {{ONE_W{1'b0}}, f_s3};
	assign sg_prod_c = {{ONE_W{1'b0}}, s_s3} * {{ONE_W{1'b0}}, omf_c};
	assign p_prod_c  = {{ONE_W{1'b0}}, v_s3} * {{ONE_W{1'b0}}, oms_c};

	always_ff @(posedge clk) begin
		if (pipe.en[4]) begin
			sec_s4 <= sec_s3;
			v_s4   <= v_s3;
			p_s4   <= p_prod_c[FRAC_BITS +: ONE_W];
			a_s4   <= Q_ONE - {1'b0, sf_prod_c[FRAC_BITS +: FRAC_BITS]};
			b_s4   <= Q_ONE - sg_prod_c[FRAC_BITS +: ONE_W];
		end
	end

	// Stage 5: q and t, then the sector routes v, p, q and t to the channels.
	assign q_prod_c = {{ONE_W{1'b0}}, v_s4} * {{ONE_W{1'b0}}, a_s4};
	assign t_prod_c = {{ONE_W{1'b0}}, v_s4} * {{ONE_W{1'b0}}, b_s4};
	assign q_c      = q_prod_c[FRAC_BITS +: ONE_W];
	assign t_c      = t_prod_c[FRAC_BITS +: ONE_W];

	always_ff @(posedge clk) begin
		if (pipe.en[5]) begin
			case (sec_s4)
				SEC_RED_YEL: begin
					red_s5 <= v_s4; green_s5 <= t_c; blue_s5 <= p_s4;
				end
				SEC_YEL_GRN: begin
					red_s5 <= q_c; green_s5 <= v_s4; blue_s5 <= p_s4;
				end
				SEC_GRN_CYN: begin
					red_s5 <= p_s4; green_s5 <= v_s4; blue_s5 <= t_c;
				end
				SEC_CYN_BLU: begin
					red_s5 <= p_s4; green_s5 <= q_c; blue_s5 <= v_s4;
				end
				SEC_BLU_MAG: begin
					red_s5 <= t_c; green_s5 <= p_s4; blue_s5 <= v_s4;
				end
				default: begin
					red_s5 <= v_s4; green_s5 <= p_s4; blue_s5 <= q_c;
				end
			endcase
		end
	end

endmodule

>>> sv/distortion_color_ramp_hsv_core.sv
// Top level of the distortion color ramp HSV to RGB converter.
// Instantiates dcr_ctrl, dcr_hue and dcr_rgb; depends on dcr_pkg and the interfaces in dcr_if.
`timescale 1ns / 1ps

// The block converts one color per transaction from HSV to RGB, all values unsigned
// Q1.16 fractions. In mode 0 the transaction carries hue, saturation and value; in mode 1
// it carries a Q4.16 distortion ratio that is clamped to 1.0 .. 1.5 and mapped to the hue
// (2 - 4(d - 1)) / 3 with saturation 0.7 and value 0.65. Inputs above 1.0 saturate, a hue
// of 1.0 wraps to 0, and zero saturation gives grey. The datapath is a five-stage pipeline
// with no state between transactions: it accepts one transaction every clock cycle unless
// a stalled output has filled every stage; results leave in the order they arrived.
// No stage path holds more than one multiplier, of at most 19 by 18 bits (the divide
// by three of the ramp hue and the HSV products), and the fifth stage is the output
// register. Input ready is combinational from output ready through the valid bits, so a
// stalled output only backs up the input once every stage holds a transaction; bubbles
// inside the pipeline are squeezed out during a stall. Reset clears only the valid bits.
module distortion_color_ramp_hsv_core import dcr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	dcr_hsv_if.sink    hsv,
	dcr_rgb_if.source  rgb
);

	dcr_pipe_t        pipe;
	logic [ONE_W-1:0] h_s2, s_s2, v_s2;
	logic             in_ready;

	// Valid bits and the stall chain.
	dcr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (hsv.valid),
		.out_ready (rgb.ready),
		.in_ready  (in_ready),
		.pipe      (pipe)
	);

	// Stages one and two produce the hue, saturation and value to convert.
	dcr_hue u_hue (
		.clk   (clk),
		.pipe  (pipe),
		.mode  (hsv.mode),
		.hue   (hsv.hue),
		.sat   (hsv.sat),
		.val   (hsv.val),
		.ratio (hsv.ratio),
		.h_s2  (h_s2),
		.s_s2  (s_s2),
		.v_s2  (v_s2)
	);

	// Stages three to five run the HSV to RGB conversion; stage five is the output register.
	dcr_rgb u_rgb (
		.clk      (clk),
		.pipe     (pipe),
		.h_s2     (h_s2),
		.s_s2     (s_s2),
		.v_s2     (v_s2),
		.red_s5   (rgb.red),
		.green_s5 (rgb.green),
		.blue_s5  (rgb.blue)
	);

	assign hsv.ready = in_ready;
	assign rgb.valid = pipe.vld[NSTG];

`ifndef SYNTHESIS
	// An accepted transaction always lands in the first stage.
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		hsv.valid && hsv.ready |=> pipe.vld[1])
		else $error("accepted transaction did not enter stage one");

	// With every stage full and the output stalled, the input must not accept.
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(&pipe.vld) && !rgb.ready |-> !hsv.ready)
		else $error("input accepted while the pipeline is full and stalled");

	// The number of transactions in flight grows by at most one per cycle.
	a_occupancy: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> $countones(pipe.vld) <= $past($countones(pipe.vld)) + 1)
		else $error("pipeline occupancy grew by more than one");
`endif

endmodule

>>> verif/dcr_rgb_checker.sv
// Checker for the distortion color ramp HSV converter: watches both streams,
// predicts each RGB result and compares it with what the block delivers.
// Depends on dcr_pkg and the stream interfaces in dcr_if.
`timescale 1ns / 1ps

module dcr_rgb_checker import dcr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	dcr_hsv_if          hsv,
	dcr_rgb_if          rgb,
	output int unsigned mismatches,
	output int unsigned in_flight
);

	typedef struct packed {
		logic [ONE_W-1:0] red;
		logic [ONE_W-1:0] green;
		logic [ONE_W-1:0] blue;
	} rgb_px_t;

	localparam logic [63:0] UNIT = 64'(Q_ONE);

	rgb_px_t pending_rgb[$];

	// Expected color for one input transaction, computed in wide unsigned arithmetic.
	function automatic rgb_px_t convert_hsv(logic m, logic [ONE_W-1:0] hue_in,
			logic [ONE_W-1:0] sat_in, logic [ONE_W-1:0] val_in,
			logic [RATIO_W-1:0] ratio_in);
		logic [63:0] h, s, v, d, h6, f, p, q, t, r, g, b;
		sector_t     sec;
		rgb_px_t     px;
		if (!m) begin
			h = (hue_in > Q_ONE) ? UNIT : 64'(hue_in);
			s = (sat_in > Q_ONE) ? UNIT : 64'(sat_in);
			v = (val_in > Q_ONE) ? UNIT : 64'(val_in);
		end else begin
			d = 64'(ratio_in);
			if (d < 64'(RATIO_LO))
				d = 64'(RATIO_LO);
			if (d > 64'(RATIO_HI))
				d = 64'(RATIO_HI);
			h = (2 * UNIT - 4 * (d - UNIT)) / 3;
			s = 64'(RAMP_SAT);
			v = 64'(RAMP_VAL);
		end
		if (h >= UNIT)
			h = 0;
		if (s == 0) begin
			r = v;
			g = v;
			b = v;
		end else begin
			h6  = h * 6;
			sec = sector_t'(h6[FRAC_BITS+2:FRAC_BITS]);
			f   = h6 & (UNIT - 1);
			p   = (v * (UNIT - s)) >> FRAC_BITS;
			q   = (v * (UNIT - ((s * f) >> FRAC_BITS))) >> FRAC_BITS;
			t   = (v * (UNIT - ((s * (UNIT - f)) >> FRAC_BITS))) >> FRAC_BITS;
			case (sec)
				SEC_RED_YEL: begin r = v; g = t; b = p; end
				SEC_YEL_GRN: begin r = q; g = v; b = p; end
				SEC_GRN_CYN: begin r = p; g = v; b = t; end
				SEC_CYN_BLU: begin r = p; g = q; b = v; end
				SEC_BLU_MAG: begin r = t; g = p; b = v; end
				default: begin r = v; g = p; b = q; end
			endcase
		end
		px.red   = r[ONE_W-1:0];
		px.green = g[ONE_W-1:0];
		px.blue  = b[ONE_W-1:0];
		return px;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rgb_px_t     want;
		rgb_px_t     got;
		rgb_px_t     fresh;
		int unsigned popped;
		int unsigned pushed;
		if (!arst_n) begin
			pending_rgb.delete();
			in_flight <= 0;
		end else begin
			popped = 0;
			pushed = 0;
			if (rgb.valid && rgb.ready) begin
				got = {rgb.red, rgb.green, rgb.blue};
				if (pending_rgb.size() == 0) begin
					if (mismatches < 10)
						$display("%0t: RGB transaction with none expected:",
							$realtime, " r=%0d g=%0d b=%0d",
							got.red, got.green, got.blue);
					mismatches <= mismatches + 1;
				end else begin
					want   = pending_rgb.pop_front();
					popped = 1;
					if (want.red !== got.red || want.green !== got.green ||
							want.blue !== got.blue) begin
						if (mismatches < 10)
							$display("%0t: RGB mismatch:", $realtime,
								" expected r=%0d g=%0d b=%0d,",
								want.red, want.green, want.blue,
								" got r=%0d g=%0d b=%0d",
								got.red, got.green, got.blue);
						mismatches <= mismatches + 1;
					end
				end
			end
			if (hsv.valid && hsv.ready) begin
				fresh = convert_hsv(hsv.mode, hsv.hue, hsv.sat, hsv.val, hsv.ratio);
				pending_rgb = {pending_rgb, fresh};
				pushed = 1;
			end
			in_flight <= in_flight + pushed - popped;
		end
	end

endmodule

>>> verif/tb.sv
// Testbench top for the distortion color ramp HSV converter.
// Drives HSV transactions and output stalls; the dcr_rgb_checker module predicts and compares.
// Depends on dcr_pkg, dcr_if, dcr_rgb_checker and distortion_color_ramp_hsv_core.
`timescale 1ns / 1ps

module tb;
	import dcr_pkg::*;

	// Number of random transactions after the directed ones, and how many of them at the
	// end run with no idling on either side.
	localparam int RAND_ITEMS  = 2000;
	localparam int QUIET_ITEMS = 300;
	// Worst case is roughly the longest input gap plus the longest output stall per
	// transaction; the limit leaves a wide margin above that.
	localparam int CYCLE_LIMIT = 200000;

	localparam logic [ONE_W-1:0]   FRAC_ALL  = '1;
	localparam logic [RATIO_W-1:0] RATIO_ALL = '1;

	logic        clk = 1'b0;
	logic        arst_n;
	int unsigned mismatches;
	int unsigned in_flight;
	int unsigned cycles = 0;

	// Shared idling controls, set by the main sequence, read by the sender and the stall process.
	bit quiet     = 1'b0;
	int gap_pct   = 0;
	int stall_pct = 0;

	dcr_hsv_if hsv_ch ();
	dcr_rgb_if rgb_ch ();

	distortion_color_ramp_hsv_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.hsv    (hsv_ch),
		.rgb    (rgb_ch)
	);

	dcr_rgb_checker i_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.hsv        (hsv_ch),
		.rgb        (rgb_ch),
		.mismatches (mismatches),
		.in_flight  (in_flight)
	);

	always #5 clk = ~clk;

	// Watchdog. A hung handshake or a lost result ends the run here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Offers one transaction and returns right after the edge at which it was accepted.
	// Before that it may drop valid for a random burst of idle cycles. Ready is sampled
	// at the falling edge, where all inputs and the block's outputs are settled, so the
	// decision never depends on event order at the rising edge.
	task automatic send_color(input logic m, input logic [ONE_W-1:0] h,
			input logic [ONE_W-1:0] s, input logic [ONE_W-1:0] v,
			input logic [RATIO_W-1:0] r);
		logic taken;
		if (!quiet && $urandom_range(0, 99) < gap_pct) begin
			hsv_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		hsv_ch.valid <= 1'b1;
		hsv_ch.mode  <= m;
		hsv_ch.hue   <= h;
		hsv_ch.sat   <= s;
		hsv_ch.val   <= v;
		hsv_ch.ratio <= r;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = hsv_ch.ready;
			@(posedge clk);
		end
	endtask

	// Random Q1.16 field: mostly in range, with a good share of zero, one, values just
	// around one and the all-ones pattern, which saturates to one.
	function automatic logic [ONE_W-1:0] pick_frac();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return Q_ONE;
			2: return ONE_W'($urandom);
			3: begin
				case ($urandom_range(0, 3))
					0: return ONE_W'(Q_ONE - 1);
					1: return ONE_W'(Q_ONE + 1);
					2: return FRAC_ALL;
					default: return ONE_W'(1);
				endcase
			end
			default: return ONE_W'($urandom_range(0, int'(Q_ONE)));
		endcase
	endfunction

	// Random Q4.16 ratio: in the ramp window, at or just past its edges, zero, all ones or noise.
	function automatic logic [RATIO_W-1:0] pick_ratio();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return RATIO_W'(RATIO_LO - 1);
			2: return RATIO_W'(RATIO_HI + 1);
			3: return ($urandom_range(0, 1) != 0) ? RATIO_LO : RATIO_HI;
			4: return RATIO_ALL;
			5, 6: return RATIO_W'($urandom);
			default: return RATIO_W'($urandom_range(int'(RATIO_LO), int'(RATIO_HI)));
		endcase
	endfunction

	// Output side: ready drops for random bursts of random length, never in the quiet
	// stretch at the end of the run. After each burst ready goes high before another can start.
	initial begin
		int stall_left;
		bit rest;
		stall_left   = 0;
		rest         = 1'b0;
		rgb_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				rgb_ch.ready <= 1'b0;
				stall_left--;
			end else if (!quiet && !rest && $urandom_range(0, 99) < stall_pct) begin
				rgb_ch.ready <= 1'b0;
				stall_left = $urandom_range(1, 8) - 1;
				rest       = 1'b1;
			end else begin
				rgb_ch.ready <= 1'b1;
				rest         = 1'b0;
			end
		end
	end

	initial begin
		int n;
		int drain;
		arst_n       = 1'b0;
		hsv_ch.valid = 1'b0;
		hsv_ch.mode  = 1'b0;
		hsv_ch.hue   = '0;
		hsv_ch.sat   = '0;
		hsv_ch.val   = '0;
		hsv_ch.ratio = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed transactions with light idling on both sides.
		gap_pct   = 20;
		stall_pct = 20;
		// Hue zero at full saturation and value.
		send_color(1'b0, '0, Q_ONE, Q_ONE, '0);
		// One hue inside each of the six sectors.
		send_color(1'b0, ONE_W'(5000), ONE_W'(40000), ONE_W'(50000), '0);
		send_color(1'b0, ONE_W'(15000), ONE_W'(40000), ONE_W'(50000), '0);
		send_color(1'b0, ONE_W'(25000), ONE_W'(40000), ONE_W'(50000), '0);
		send_color(1'b0, ONE_W'(35000), ONE_W'(40000), ONE_W'(50000), '0);
		send_color(1'b0, ONE_W'(45000), ONE_W'(40000), ONE_W'(50000), '0);
		send_color(1'b0, ONE_W'(60000), ONE_W'(40000), ONE_W'(50000), '0);
		// A hue of exactly one wraps to red.
		send_color(1'b0, Q_ONE, Q_ONE, Q_ONE, '0);
		// Every field above one saturates, and the saturated hue wraps too.
		send_color(1'b0, FRAC_ALL, FRAC_ALL, FRAC_ALL, '0);
		// Largest hue below one, with zero value.
		send_color(1'b0, ONE_W'(Q_ONE - 1), Q_ONE, '0, '0);
		// Zero saturation gives grey, also with a value that saturates.
		send_color(1'b0, ONE_W'(20000), '0, ONE_W'(30000), '0);
		send_color(1'b0, ONE_W'(20000), '0, FRAC_ALL, '0);
		// In direct mode the ratio is ignored.
		send_color(1'b0, ONE_W'(12345), ONE_W'(33333), ONE_W'(44444), RATIO_ALL);
		// Ramp mode: ratio below, at and above the clamp window, with junk HSV fields.
		send_color(1'b1, FRAC_ALL, FRAC_ALL, FRAC_ALL, '0);
		send_color(1'b1, '0, '0, '0, RATIO_W'(RATIO_LO - 1));
		send_color(1'b1, '0, '0, '0, RATIO_LO);
		send_color(1'b1, '0, '0, '0, RATIO_W'(RATIO_LO + 1));
		send_color(1'b1, '0, '0, '0, RATIO_LO + (RATIO_LO >> 2));
		send_color(1'b1, '0, '0, '0, RATIO_W'(RATIO_HI - 1));
		send_color(1'b1, '0, '0, '0, RATIO_HI);
		send_color(1'b1, '0, '0, '0, RATIO_W'(RATIO_HI + 1));
		send_color(1'b1, FRAC_ALL, '0, Q_ONE, RATIO_ALL);

		// Random transactions. The idling levels change every couple of hundred
		// transactions so that long stretches run back to back as well.
		for (n = 0; n < RAND_ITEMS; n++) begin
			if (n % 200 == 0) begin
				case ($urandom_range(0, 3))
					0: gap_pct = 0;
					1: gap_pct = 10;
					2: gap_pct = 35;
					default: gap_pct = 70;
				endcase
				case ($urandom_range(0, 3))
					0: stall_pct = 0;
					1: stall_pct = 10;
					2: stall_pct = 35;
					default: stall_pct = 70;
				endcase
			end
			if (n == RAND_ITEMS - QUIET_ITEMS)
				quiet = 1'b1;
			// Hold off once in the middle until the pipeline has fully drained. The
			// count seen after an edge is the one from the edge before, so the wait first
			// lets the clock advance to include the transaction just accepted.
			if (n == RAND_ITEMS / 2) begin
				hsv_ch.valid <= 1'b0;
				@(posedge clk);
				while (in_flight != 0) @(posedge clk);
			end
			send_color(1'($urandom_range(0, 1)), pick_frac(), pick_frac(), pick_frac(),
				pick_ratio());
		end
		hsv_ch.valid <= 1'b0;

		// Wait for every expected result, then give the pipeline time to show any
		// stray transaction before the verdict.
		@(posedge clk);
		while (in_flight != 0) @(posedge clk);
		drain = NSTG * 4;
		repeat (drain) @(posedge clk);
		if (mismatches == 0 && in_flight == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
